/* rtl/ffa_pkg.sv */
// shared types and constants of the first-fit heap allocator
package ffa_pkg;

  localparam int unsigned MAX_BLOCKS = 64;
  localparam int unsigned HEAP_BYTES = 1048576;
  localparam int unsigned IDX_W      = $clog2(MAX_BLOCKS);
  localparam int unsigned PTR_W      = IDX_W + 1;
  localparam int unsigned ADDR_W     = 21;
  localparam int unsigned SUM_W      = ADDR_W + 1;
  localparam int unsigned HDR_W      = 7;
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned STAT_W     = 2;
  localparam int unsigned PADDR_W    = 3;
  localparam int unsigned PDATA_W    = 32;

  localparam logic [PTR_W-1:0] NIL = PTR_W'(MAX_BLOCKS);

  // request kinds
  localparam logic [MODE_W-1:0] MODE_ALLOC  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FREE   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RESIZE = 2'd2;

  // result status codes
  localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
  localparam logic [STAT_W-1:0] STAT_OOM     = 2'd1;
  localparam logic [STAT_W-1:0] STAT_UNKNOWN = 2'd2;

  // register indexes
  localparam logic REG_HEADER = 1'b0;
  localparam logic REG_LIMIT  = 1'b1;

  typedef struct packed {
    logic [ADDR_W-1:0] start;
    logic [ADDR_W-1:0] bytes;
    logic              is_free;
    logic [PTR_W-1:0]  succ;
  } entry_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [ADDR_W-1:0] payload_addr;
    logic [ADDR_W-1:0] req_size;
  } req_t;

  typedef struct packed {
    logic [ADDR_W-1:0] result_addr;
    logic [STAT_W-1:0] status;
    logic              copy_needed;
    logic [ADDR_W-1:0] copy_from;
    logic [ADDR_W-1:0] copy_len;
  } rsp_t;

  typedef struct packed {
    logic [HDR_W-1:0]  header_bytes;
    logic [ADDR_W-1:0] heap_limit;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_CHK,
    ST_END,
    ST_WR_CUR,
    ST_WR_PREV,
    ST_WR_OLD,
    ST_DONE
  } state_e;

endpackage

/* rtl/ffa_ram.sv */
// generic single write port ram with registered read
module ffa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

/* rtl/ffa_cfg.sv */
// apb configuration registers of the allocator
module ffa_cfg import ffa_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output cfg_t               cfg_o
);

  cfg_t cfg_q, cfg_d;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  // register write decode
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (paddr[2])
        REG_HEADER: cfg_d.header_bytes = pwdata[HDR_W-1:0];
        REG_LIMIT:  cfg_d.heap_limit   = pwdata[ADDR_W-1:0];
        default:    cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.header_bytes <= HDR_W'(24);
      cfg_q.heap_limit   <= ADDR_W'(1048576);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // read back
  always_comb begin
    case (paddr[2])
      REG_HEADER: prdata = PDATA_W'(cfg_q.header_bytes);
      REG_LIMIT:  prdata = PDATA_W'(cfg_q.heap_limit);
      default:    prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

/* rtl/first_fit_heap_allocator_core.sv */
// top level: first-fit allocator sequencer around the block table ram
// First-fit heap allocator over an address-ordered block list.
// Requests arrive on in_req_i with in_valid_i/in_ready_o: allocate, release
// or resize. Each request gives exactly one result on out_rsp_o with
// out_valid_o/out_ready_i: payload address, status and, for a resize that
// moved, the copy to perform.
// The block table lives in one ram with a registered read; the list is
// walked one entry per cycle, the next read address taken straight from the
// successor field just read. A resize that moves walks the list twice.
// One request is in work at a time; in_ready_o is high while idle.
// The result sits in an output register, so a new request is taken while a
// finished result still waits; a stalled receiver holds it, and the next
// result waits in the done state until the register frees.
// Reset empties the list, clears the fill count and heap top and loads the
// default header size and heap limit. Table entries need no clearing since
// only entries reachable from the list are read.
// Configuration by APB (header bytes at 0x0, heap limit at 0x4); the user writes
// it only while idle, which the block itself does not enforce.
module first_fit_heap_allocator_core import ffa_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  req_t               in_req_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output rsp_t               out_rsp_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  cfg_t cfg;

  ffa_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg_o  (cfg)
  );

  // block table
  logic             rd_en, wr_en;
  logic [IDX_W-1:0] rd_addr, wr_addr;
  entry_t           rd_data, wr_data;

  ffa_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(MAX_BLOCKS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(wr_addr),
    .wdata_i(wr_data),
    .re_i   (rd_en),
    .raddr_i(rd_addr),
    .rdata_o(rd_data)
  );

  state_e           state_q, state_d;
  req_t             req_q, req_d;
  rsp_t             res_q, res_d, out_q, out_d;
  logic             out_valid_q, out_valid_d;
  logic [PTR_W-1:0] cur_q, cur_d, prev_q, prev_d, b_q, b_d, n_q, n_d;
  logic [PTR_W-1:0] list_first_q, list_first_d, used_q, used_d, steps_q, steps_d;
  entry_t           cur_ent_q, cur_ent_d, prev_ent_q, prev_ent_d, b_ent_q, b_ent_d;
  logic             find_q, find_d, move_q, move_d;
  logic [ADDR_W-1:0] heap_top_q, heap_top_d;

  // widened operands
  logic [SUM_W-1:0] hdr_w, size_w, limit_w, grow_end, hit_addr, split_need;
  logic             table_full;

  assign hdr_w      = SUM_W'(cfg.header_bytes);
  assign size_w     = SUM_W'(req_q.req_size);
  assign limit_w    = (SUM_W'(cfg.heap_limit) < SUM_W'(HEAP_BYTES)) ?
                      SUM_W'(cfg.heap_limit) : SUM_W'(HEAP_BYTES);
  assign grow_end   = SUM_W'(heap_top_q) + hdr_w + size_w;
  assign hit_addr   = SUM_W'(rd_data.start) + hdr_w;
  assign split_need = size_w + hdr_w;
  assign table_full = (used_q >= PTR_W'(MAX_BLOCKS));

  // sequencer: walk, update, hand over result
  always_comb begin
    state_d      = state_q;
    req_d        = req_q;
    res_d        = res_q;
    out_d        = out_q;
    out_valid_d  = out_valid_q & ~out_ready_i;
    cur_d        = cur_q;
    prev_d       = prev_q;
    b_d          = b_q;
    n_d          = n_q;
    list_first_d = list_first_q;
    used_d       = used_q;
    steps_d      = steps_q;
    cur_ent_d    = cur_ent_q;
    prev_ent_d   = prev_ent_q;
    b_ent_d      = b_ent_q;
    find_d       = find_q;
    move_d       = move_q;
    heap_top_d   = heap_top_q;
    rd_en        = 1'b0;
    rd_addr      = cur_q[IDX_W-1:0];
    wr_en        = 1'b0;
    wr_addr      = cur_q[IDX_W-1:0];
    wr_data      = cur_ent_q;
    in_ready_o   = 1'b0;

    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          req_d   = in_req_i;
          res_d   = '0;
          cur_d   = list_first_q;
          prev_d  = NIL;
          steps_d = '0;
          move_d  = 1'b0;
          find_d  = 1'b0;
          case (in_req_i.mode)
            MODE_ALLOC: state_d = ST_START;
            MODE_FREE: begin
              find_d  = 1'b1;
              state_d = (in_req_i.payload_addr == '0) ? ST_DONE : ST_START;
            end
            MODE_RESIZE: begin
              find_d  = (in_req_i.payload_addr != '0);
              state_d = ST_START;
            end
            default: state_d = ST_DONE;
          endcase
        end
      end

      ST_START: begin
        if (cur_q < NIL) begin
          rd_en   = 1'b1;
          state_d = ST_CHK;
        end else begin
          state_d = ST_END;
        end
      end

      ST_CHK: begin
        if (find_q && !rd_data.is_free && hit_addr == SUM_W'(req_q.payload_addr)) begin
          // in-use block found
          b_d     = cur_q;
          b_ent_d = rd_data;
          if (req_q.mode == MODE_FREE || req_q.req_size == '0) begin
            wr_en           = 1'b1;
            wr_data         = rd_data;
            wr_data.is_free = 1'b1;
            state_d         = ST_DONE;
          end else if (rd_data.bytes >= req_q.req_size) begin
            res_d.result_addr = req_q.payload_addr;
            state_d           = ST_DONE;
          end else begin
            move_d  = 1'b1;
            find_d  = 1'b0;
            cur_d   = list_first_q;
            prev_d  = NIL;
            steps_d = '0;
            state_d = ST_START;
          end
        end else if (!find_q && rd_data.is_free && rd_data.bytes >= req_q.req_size) begin
          // first fit, split when the leftover holds a header and the table has room
          cur_ent_d         = rd_data;
          cur_ent_d.is_free = 1'b0;
          if (SUM_W'(rd_data.bytes) >= split_need && !table_full) begin
            wr_en           = 1'b1;
            wr_addr         = used_q[IDX_W-1:0];
            wr_data.start   = ADDR_W'(hit_addr + size_w);
            wr_data.bytes   = ADDR_W'(SUM_W'(rd_data.bytes) - split_need);
            wr_data.is_free = 1'b1;
            wr_data.succ    = rd_data.succ;
            used_d          = used_q + 1'b1;
            cur_ent_d.bytes = req_q.req_size;
            cur_ent_d.succ  = used_q;
          end
          res_d.result_addr = ADDR_W'(hit_addr);
          state_d           = ST_WR_CUR;
        end else begin
          // step on to the successor
          prev_d     = cur_q;
          prev_ent_d = rd_data;
          cur_d      = rd_data.succ;
          steps_d    = steps_q + 1'b1;
          if (rd_data.succ < NIL && steps_q < PTR_W'(MAX_BLOCKS - 1)) begin
            rd_en   = 1'b1;
            rd_addr = rd_data.succ[IDX_W-1:0];
          end else begin
            state_d = ST_END;
          end
        end
      end

      ST_END: begin
        if (find_q) begin
          res_d.status = STAT_UNKNOWN;
          state_d      = ST_DONE;
        end else if (table_full || grow_end > limit_w) begin
          res_d   = '0;
          res_d.status = STAT_OOM;
          state_d = ST_DONE;
        end else begin
          // grow the heap top by one block
          wr_en             = 1'b1;
          wr_addr           = used_q[IDX_W-1:0];
          wr_data.start     = heap_top_q;
          wr_data.bytes     = req_q.req_size;
          wr_data.is_free   = 1'b0;
          wr_data.succ      = NIL;
          n_d               = used_q;
          used_d            = used_q + 1'b1;
          heap_top_d        = ADDR_W'(grow_end);
          res_d.result_addr = ADDR_W'(SUM_W'(heap_top_q) + hdr_w);
          if (prev_q < NIL) begin
            state_d = ST_WR_PREV;
          end else begin
            list_first_d = used_q;
            state_d      = move_q ? ST_WR_OLD : ST_DONE;
          end
        end
      end

      ST_WR_CUR: begin
        wr_en   = 1'b1;
        state_d = move_q ? ST_WR_OLD : ST_DONE;
      end

      ST_WR_PREV: begin
        wr_en        = 1'b1;
        wr_addr      = prev_q[IDX_W-1:0];
        wr_data      = prev_ent_q;
        wr_data.succ = n_q;
        if (prev_q == b_q) begin
          b_ent_d.succ = n_q;
        end
        state_d = move_q ? ST_WR_OLD : ST_DONE;
      end

      ST_WR_OLD: begin
        wr_en             = 1'b1;
        wr_addr           = b_q[IDX_W-1:0];
        wr_data           = b_ent_q;
        wr_data.is_free   = 1'b1;
        res_d.copy_needed = 1'b1;
        res_d.copy_from   = req_q.payload_addr;
        res_d.copy_len    = b_ent_q.bytes;
        state_d           = ST_DONE;
      end

      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      out_valid_q  <= 1'b0;
      list_first_q <= NIL;
      used_q       <= '0;
      heap_top_q   <= '0;
    end else begin
      state_q      <= state_d;
      out_valid_q  <= out_valid_d;
      list_first_q <= list_first_d;
      used_q       <= used_d;
      heap_top_q   <= heap_top_d;
    end
  end

  // walk and payload registers
  always_ff @(posedge clk_i) begin
    req_q      <= req_d;
    res_q      <= res_d;
    out_q      <= out_d;
    cur_q      <= cur_d;
    prev_q     <= prev_d;
    b_q        <= b_d;
    n_q        <= n_d;
    steps_q    <= steps_d;
    cur_ent_q  <= cur_ent_d;
    prev_ent_q <= prev_ent_d;
    b_ent_q    <= b_ent_d;
    find_q     <= find_d;
    move_q     <= move_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  // checks
  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= PTR_W'(MAX_BLOCKS))
    else $error("fill count beyond table depth");

  a_wr_in_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (PTR_W'(wr_addr) <= used_q))
    else $error("table write beyond filled entries");

  a_copy_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.copy_needed) |-> (out_q.status == STAT_OK))
    else $error("copy reported on a failed request");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.status == STAT_OK || out_q.status == STAT_OOM ||
                     out_q.status == STAT_UNKNOWN))
    else $error("undefined status code");

endmodule

/* verif/testbench.sv */
// self-checking testbench for the first-fit heap allocator core
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import ffa_pkg::*;

  // allocator model and store of expected results
  class heap_scoreboard;
    int unsigned blk_start[MAX_BLOCKS];
    int unsigned blk_bytes[MAX_BLOCKS];
    bit          blk_free[MAX_BLOCKS];
    int unsigned blk_next[MAX_BLOCKS];
    int unsigned head_idx, fill, top, hdr, lim;
    rsp_t        due_q[$];
    int          mismatches, checked;

    function new();
      head_idx = MAX_BLOCKS;
      fill     = 0;
      top      = 0;
      hdr      = 24;
      lim      = 1048576;
    endfunction

    function void set_reg(logic idx, int unsigned val);
      if (idx == REG_HEADER) hdr = val & 32'h7f;
      else lim = val & 32'h1fffff;
    endfunction

    // first fit, else grow the heap top
    function bit carve(int unsigned size, output int unsigned addr);
      int unsigned prev, cur, steps, n, cap;
      longint unsigned fin;
      prev  = MAX_BLOCKS;
      cur   = head_idx;
      steps = 0;
      addr  = 0;
      while (cur < MAX_BLOCKS && steps < MAX_BLOCKS) begin
        if (blk_free[cur] && blk_bytes[cur] >= size) begin
          if (longint'(blk_bytes[cur]) >= longint'(size) + hdr && fill < MAX_BLOCKS) begin
            n = fill;
            fill++;
            blk_start[n] = blk_start[cur] + hdr + size;
            blk_bytes[n] = blk_bytes[cur] - size - hdr;
            blk_free[n]  = 1'b1;
            blk_next[n]  = blk_next[cur];
            blk_bytes[cur] = size;
            blk_next[cur]  = n;
          end
          blk_free[cur] = 1'b0;
          addr = (blk_start[cur] + hdr) & 32'h1fffff;
          return 1'b1;
        end
        prev = cur;
        cur  = blk_next[cur];
        steps++;
      end
      if (fill >= MAX_BLOCKS) return 1'b0;
      cap = (lim < HEAP_BYTES) ? lim : HEAP_BYTES;
      fin = longint'(top) + hdr + size;
      if (fin > cap) return 1'b0;
      n = fill;
      fill++;
      blk_start[n] = top;
      blk_bytes[n] = size;
      blk_free[n]  = 1'b0;
      blk_next[n]  = MAX_BLOCKS;
      if (prev < MAX_BLOCKS) blk_next[prev] = n;
      else head_idx = n;
      top  = 32'(fin);
      addr = (blk_start[n] + hdr) & 32'h1fffff;
      return 1'b1;
    endfunction

    function int unsigned lookup(int unsigned addr);
      int unsigned cur, steps;
      cur   = head_idx;
      steps = 0;
      while (cur < MAX_BLOCKS && steps < MAX_BLOCKS) begin
        if (!blk_free[cur] && blk_start[cur] + hdr == addr) return cur;
        cur = blk_next[cur];
        steps++;
      end
      return MAX_BLOCKS;
    endfunction

    // accepted request: predict its result and queue it
    function rsp_t note_request(req_t rq);
      rsp_t        r;
      int unsigned a, b, na;
      r = '0;
      a = 32'(rq.payload_addr);
      if (rq.mode == MODE_ALLOC) begin
        if (carve(32'(rq.req_size), na)) r.result_addr = ADDR_W'(na);
        else r.status = STAT_OOM;
      end else if (rq.mode == MODE_FREE) begin
        if (a != 0) begin
          b = lookup(a);
          if (b < MAX_BLOCKS) blk_free[b] = 1'b1;
          else r.status = STAT_UNKNOWN;
        end
      end else if (rq.mode == MODE_RESIZE) begin
        if (a == 0) begin
          if (carve(32'(rq.req_size), na)) r.result_addr = ADDR_W'(na);
          else r.status = STAT_OOM;
        end else begin
          b = lookup(a);
          if (b >= MAX_BLOCKS) r.status = STAT_UNKNOWN;
          else if (rq.req_size == 0) blk_free[b] = 1'b1;
          else if (blk_bytes[b] >= rq.req_size) r.result_addr = ADDR_W'(a);
          else if (carve(32'(rq.req_size), na)) begin
            r.result_addr = ADDR_W'(na);
            r.copy_needed = 1'b1;
            r.copy_from   = ADDR_W'(a);
            r.copy_len    = ADDR_W'(blk_bytes[b]);
            blk_free[b]   = 1'b1;
          end else r.status = STAT_OOM;
        end
      end
      due_q.push_back(r);
      return r;
    endfunction

    function void check_result(rsp_t got);
      rsp_t want;
      if (due_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
        return;
      end
      want = due_q.pop_front();
      checked++;
      if (got.result_addr !== want.result_addr || got.status !== want.status ||
          got.copy_needed !== want.copy_needed || got.copy_from !== want.copy_from ||
          got.copy_len !== want.copy_len) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result mismatch: expected %p, got %p", want, got);
      end
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  req_t               in_req;
  logic               out_valid;
  logic               out_ready;
  rsp_t               out_rsp;
  logic               psel, penable, pwrite, pready;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata, prdata;

  heap_scoreboard     sb;
  int unsigned        handed_q[$];
  int unsigned        sent, cfg_writes;
  bit                 choke;

  first_fit_heap_allocator_core dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .in_req_i(in_req),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_rsp_o(out_rsp),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // result side: check each transfer
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_rsp);
  end

  // receiver: random stalls, one long hold-off on request
  initial begin
    int unsigned k;
    out_ready = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      k = choke ? 400 : ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 3));
      if (choke) choke = 1'b0;
      if (k > 0) begin
        out_ready <= 1'b0;
        repeat (k) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // run limit
  initial begin
    #20ms;
    $display("timeout");
    $display("== FAIL ==");
    $finish;
  end

  task automatic reg_write(logic idx, int unsigned val);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    sb.set_reg(idx, val);
    cfg_writes++;
  endtask

  // one request transfer, with a random gap before it
  task automatic send(req_t rq);
    int unsigned gap;
    rsp_t        r;
    gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= rq;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    r = sb.note_request(rq);
    sent++;
    if (r.result_addr != 0) begin
      handed_q.push_back(32'(r.result_addr));
      if (handed_q.size() > 48) void'(handed_q.pop_front());
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.due_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  function automatic int unsigned pick_addr();
    if (handed_q.size() == 0) return $urandom_range(1, 4000);
    return handed_q[$urandom_range(0, handed_q.size() - 1)];
  endfunction

  function automatic int unsigned pick_size();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 80) return $urandom_range(0, 200);
    if (p < 95) return $urandom_range(0, 6000);
    return $urandom_range(0, 21'h1fffff);
  endfunction

  function automatic req_t mk(logic [MODE_W-1:0] m, int unsigned a, int unsigned s);
    req_t rq;
    rq.mode         = m;
    rq.payload_addr = ADDR_W'(a);
    rq.req_size     = ADDR_W'(s);
    return rq;
  endfunction

  task automatic random_items(int unsigned n);
    int unsigned p;
    repeat (n) begin
      p = $urandom_range(0, 99);
      if (p < 40) send(mk(MODE_ALLOC, 0, pick_size()));
      else if (p < 65) send(mk(MODE_FREE, pick_addr(), 0));
      else if (p < 88) send(mk(MODE_RESIZE, pick_addr(), pick_size()));
      else if (p < 92) send(mk(MODE_RESIZE, 0, pick_size()));
      else send(mk(MODE_W'($urandom_range(0, 3)), $urandom_range(0, 21'h1fffff),
                   $urandom_range(0, 21'h1fffff)));
    end
  endtask

  // main sequence
  initial begin
    int unsigned a;
    sb        = new();
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_req    = '0;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    choke     = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    reg_write(REG_HEADER, 24);
    reg_write(REG_LIMIT, 1048576);

    // directed: extremes, each mode and the corner cases
    send(mk(MODE_ALLOC, 0, 0));
    send(mk(MODE_ALLOC, 0, 21'h1fffff));
    send(mk(MODE_ALLOC, 0, 100));
    a = handed_q[$];
    send(mk(MODE_ALLOC, 0, 40));
    send(mk(MODE_FREE, 0, 0));
    send(mk(MODE_FREE, 21'h1fffff, 21'h1fffff));
    send(mk(MODE_FREE, a, 0));
    send(mk(MODE_FREE, a, 0));
    send(mk(MODE_ALLOC, 0, 20));
    send(mk(MODE_ALLOC, 0, 60));
    send(mk(MODE_RESIZE, 0, 30));
    a = handed_q[$];
    send(mk(MODE_RESIZE, a, 10));
    send(mk(MODE_RESIZE, a, 500));
    a = handed_q[$];
    send(mk(MODE_RESIZE, a, 21'h1fffff));
    send(mk(MODE_RESIZE, a, 0));
    send(mk(MODE_RESIZE, a, 0));
    send(mk(2'd3, 21'h1fffff, 21'h1fffff));
    drain();

    // random items, then stall the receiver long while items keep coming
    random_items(150);
    choke = 1'b1;
    random_items(60);
    drain();

    // zero header with no effective limit
    reg_write(REG_HEADER, 0);
    reg_write(REG_LIMIT, 21'h1fffff);
    send(mk(MODE_ALLOC, 0, 8));
    send(mk(MODE_FREE, 0, 0));
    random_items(300);
    drain();

    // header of 64 bytes, tight limit
    reg_write(REG_HEADER, 64);
    reg_write(REG_LIMIT, 3000);
    random_items(300);
    drain();

    // zero limit, growth always fails
    reg_write(REG_HEADER, 8);
    reg_write(REG_LIMIT, 0);
    random_items(250);
    drain();

    // random setting
    reg_write(REG_HEADER, $urandom_range(0, 64));
    reg_write(REG_LIMIT, $urandom_range(20000, 1048576));
    random_items(420);
    drain();

    $display("sent %0d requests, checked %0d results over %0d register writes",
             sent, sb.checked, cfg_writes);
    $display("header sizes 0..64 and heap limits from zero to full were exercised");
    if (sb.mismatches == 0 && sb.due_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.mismatches, sb.due_q.size());
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/ffa_pkg.sv
rtl/ffa_ram.sv
rtl/ffa_cfg.sv
rtl/first_fit_heap_allocator_core.sv
verif/testbench.sv
